// ===== hw/rtl/rob_pkg.sv =====
package rob_pkg;

  localparam int CH_W      = 8;
  localparam int NUM_COLOR = 3;
  localparam int NUM_LANES = NUM_COLOR + 1;
  localparam int ALPHA_LN  = NUM_COLOR;
  localparam int WGT_W     = 16;
  localparam int NUM_W     = 24;
  localparam int REM_W     = NUM_W + 1;
  localparam int DEN_W     = WGT_W + 1;
  localparam int QUO_W     = CH_W;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic             zero;
  } lane_t;

  typedef lane_t [NUM_LANES-1:0] lanes_t;

  function automatic lane_t div_bit(input lane_t ln, input logic [2:0] k);
    logic [REM_W-1:0] sub;
    lane_t            res;
    res = ln;
    sub = REM_W'(ln.den) << k;
    if (ln.rem >= sub) begin
      res.rem    = ln.rem - sub;
      res.quo[k] = 1'b1;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/rob_div_stage.sv =====
module rob_div_stage #(
  parameter int HI_BIT = 7
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            up_valid,
  input  rob_pkg::lanes_t up_lanes,
  output logic            dn_valid,
  output rob_pkg::lanes_t dn_lanes
);
  import rob_pkg::*;

  lanes_t lanes_next;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lanes_next[i] = up_lanes[i];
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        lanes_next[i] = div_bit(lanes_next[i], 3'(HI_BIT - b));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_lanes <= lanes_next;
    end
  end

endmodule

// ===== hw/rtl/rgba_over_blend.sv =====
// Porter-Duff over of a straight-alpha RGBA8 source pixel onto an RGBA8
// destination pixel, in exact integer arithmetic with round-half-up results.
// One pixel is accepted every clock while in_stall is low; each request passes
// through two multiply stages, one divider setup stage and four radix-4 divider
// stages, the last of which is the output register. When the output is held
// by out_stall the whole pipeline freezes and in_stall is raised, so no pixel
// is lost or repeated. Both alphas zero yield an all-zero pixel.
module rgba_over_blend (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] dst_red,
  input  logic [7:0] dst_green,
  input  logic [7:0] dst_blue,
  input  logic [7:0] dst_alpha,
  input  logic [7:0] src_red,
  input  logic [7:0] src_green,
  input  logic [7:0] src_blue,
  input  logic [7:0] src_alpha,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);
  import rob_pkg::*;

  logic adv;

  logic                 v1;
  logic [CH_W-1:0]      dc1 [NUM_COLOR];
  logic [CH_W-1:0]      sc1 [NUM_COLOR];
  logic [WGT_W-1:0]     wd1;
  logic [WGT_W-1:0]     ws1;

  logic                 v2;
  logic [NUM_W-1:0]     num2 [NUM_COLOR];
  logic [WGT_W-1:0]     asum2;

  logic                 v3;
  lanes_t               lanes3;
  lanes_t               lanes3_next;

  logic                 dv [DIV_STAGES+1];
  lanes_t               dl [DIV_STAGES+1];

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dc1[0] <= dst_red;
      dc1[1] <= dst_green;
      dc1[2] <= dst_blue;
      sc1[0] <= src_red;
      sc1[1] <= src_green;
      sc1[2] <= src_blue;
      wd1    <= WGT_W'(dst_alpha) * WGT_W'(CH_MAX - src_alpha);
      ws1    <= WGT_W'(src_alpha) * WGT_W'(CH_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_COLOR; i++) begin
        num2[i] <= NUM_W'(dc1[i]) * NUM_W'(wd1) + NUM_W'(sc1[i]) * NUM_W'(ws1);
      end
      asum2 <= wd1 + ws1;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_COLOR; i++) begin
      lanes3_next[i].rem  = {num2[i], 1'b0} + REM_W'(asum2);
      lanes3_next[i].den  = {asum2, 1'b0};
      lanes3_next[i].quo  = '0;
      lanes3_next[i].zero = (asum2 == '0);
    end
    lanes3_next[ALPHA_LN].rem  = REM_W'({asum2, 1'b0}) + REM_W'(CH_MAX);
    lanes3_next[ALPHA_LN].den  = DEN_W'({CH_MAX, 1'b0});
    lanes3_next[ALPHA_LN].quo  = '0;
    lanes3_next[ALPHA_LN].zero = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lanes3 <= lanes3_next;
    end
  end

  assign dv[0] = v3;
  assign dl[0] = lanes3;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    rob_div_stage #(
      .HI_BIT(QUO_W - 1 - g * BITS_PER_STAGE)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .up_valid (dv[g]),
      .up_lanes (dl[g]),
      .dn_valid (dv[g+1]),
      .dn_lanes (dl[g+1])
    );
  end

  assign out_valid = dv[DIV_STAGES];
  assign out_red   = dl[DIV_STAGES][0].zero ? '0 : dl[DIV_STAGES][0].quo;
  assign out_green = dl[DIV_STAGES][1].zero ? '0 : dl[DIV_STAGES][1].quo;
  assign out_blue  = dl[DIV_STAGES][2].zero ? '0 : dl[DIV_STAGES][2].quo;
  assign out_alpha = dl[DIV_STAGES][ALPHA_LN].quo;

`ifndef SYNTHESIS
  a_clear_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_alpha == '0 |-> out_red == '0 && out_green == '0 && out_blue == '0)
    else $error("transparent result carries color");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(v3) && $stable(lanes3))
    else $error("pipeline advanced while stalled");
`endif

endmodule
